FILE: hw/rtl/rme_pkg.sv
// Package for the register machine execute block: opcodes, status codes, widths.
// No dependencies.
`timescale 1ns / 1ps
package rme_pkg;
    localparam int REG_COUNT_DEF   = 26;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int PROG_DEPTH_DEF  = 1024;
    localparam int PCW             = 11;
    localparam int DW              = 32;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_INC = 5'd1, OP_DEC = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
        OP_MUL = 5'd5, OP_DIV = 5'd6, OP_CMP = 5'd7, OP_JMP = 5'd8, OP_JNE = 5'd9,
        OP_JE = 5'd10, OP_JG = 5'd11, OP_JGE = 5'd12, OP_JL = 5'd13, OP_JLE = 5'd14,
        OP_CALL = 5'd15, OP_RET = 5'd16, OP_END = 5'd17
    } t_op;

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_END    = 3'd1;
    localparam logic [2:0] ST_BADRET = 3'd2;
    localparam logic [2:0] ST_NOLBL  = 3'd3;
    localparam logic [2:0] ST_STACK  = 3'd4;
    localparam logic [2:0] ST_FELL   = 3'd5;
    localparam logic [2:0] ST_DIV0   = 3'd6;

    localparam logic [1:0] RA_PROG_LEN = 2'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the request operands
        logic div_start; // launch the divider
        logic commit;    // retire the instruction, update state
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div; // captured request is a divide with a nonzero divisor
        logic div_done;
    } t_sts;
endpackage

FILE: hw/rtl/rme_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rme_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/rme_div.sv
// Iterative 32-bit signed divider, truncating toward zero, one bit per cycle.
// Depends on rme_pkg.
`timescale 1ns / 1ps
module rme_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [rme_pkg::DW-1:0] i_a,
    input  logic [rme_pkg::DW-1:0] i_b,
    output logic                 o_done,
    output logic [rme_pkg::DW-1:0] o_q
);
    import rme_pkg::*;
    logic [DW-1:0] r_q, n_q, r_rem, n_rem, r_div, n_div;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [DW+1:0] w_trial;
    logic [DW:0]   w_shift;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_div = r_div; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_done = 1'b0;
        // Keep the full remainder: it can reach 33 bits after the shift
        w_shift = {r_rem, r_q[DW-1]};
        w_trial = {1'b0, w_shift} - {2'b00, r_div};
        if (i_start) begin
            // Take magnitudes and remember the sign
            n_q    = i_a[DW-1] ? (~i_a + 1'b1) : i_a;
            n_div  = i_b[DW-1] ? (~i_b + 1'b1) : i_b;
            n_rem  = '0;
            n_neg  = i_a[DW-1] ^ i_b[DW-1];
            n_cnt  = 6'(DW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Restoring step
            n_q = {r_q[DW-2:0], ~w_trial[DW+1]};
            n_rem = w_trial[DW+1] ? w_shift[DW-1:0] : w_trial[DW-1:0];
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_neg) n_q = ~{r_q[DW-2:0], ~w_trial[DW+1]} + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_div <= n_div; r_cnt <= n_cnt; r_neg <= n_neg;
    end
    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

FILE: hw/rtl/rme_ctrl.sv
// Controller state machine: sequences capture, divide and commit of one request.
// Depends on rme_pkg.
`timescale 1ns / 1ps
module rme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rme_pkg::t_sts i_sts,
    output rme_pkg::t_cmd o_cmd
);
    import rme_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_DEC, S_DIV, S_COMMIT} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // Output register frees when empty or taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: if (i_sts.div_done) n_state = S_COMMIT;
            S_COMMIT: if (w_out_free) begin
                o_cmd.commit = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: hw/rtl/rme_dp.sv
// Datapath: register file, flags, return stack, pc, status and result register.
// Depends on rme_pkg, rme_div, rme_ram.
`timescale 1ns / 1ps
module rme_dp #(
    parameter int REG_COUNT   = rme_pkg::REG_COUNT_DEF,
    parameter int STACK_DEPTH = rme_pkg::STACK_DEPTH_DEF,
    parameter int PROG_DEPTH  = rme_pkg::PROG_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rme_pkg::t_cmd      i_cmd,
    output rme_pkg::t_sts      o_sts,
    input  logic [10:0]        i_prog_len,
    input  logic [91:0]        i_req,
    output logic [47:0]        o_res
);
    import rme_pkg::*;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SDW = $clog2(STACK_DEPTH + 1);
    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DW-1:0]  r_rf [REG_COUNT];
    logic           r_zf, r_nf;
    logic [SDW-1:0] r_sd;
    logic [PCW-1:0] r_pc;
    logic [2:0]     r_st;
    logic [91:0]    r_req;
    logic [DW-1:0]  r_a, r_b;
    logic [47:0]    r_res;

    // Request fields
    logic [4:0]  w_op, w_d, w_s;
    logic        w_fimm, w_simm, w_found;
    logic [31:0] w_fv, w_sv;
    logic [9:0]  w_tgt;
    assign w_op    = r_req[4:0];
    assign w_d     = r_req[9:5];
    assign w_fimm  = r_req[10];
    assign w_fv    = r_req[42:11];
    assign w_simm  = r_req[43];
    assign w_s     = r_req[48:44];
    assign w_sv    = r_req[80:49];
    assign w_tgt   = r_req[90:81];
    assign w_found = r_req[91];

    // Operand fetch from the incoming request
    logic [4:0] w_in_d, w_in_s;
    assign w_in_d = i_req[9:5];
    assign w_in_s = i_req[48:44];
    logic [DW-1:0] w_ra, w_rb;
    always_comb begin
        w_ra = (32'(w_in_d) < 32'(REG_COUNT)) ? r_rf[w_in_d[RIW-1:0]] : '0;
        w_rb = i_req[43] ? i_req[80:49]
             : ((32'(w_in_s) < 32'(REG_COUNT)) ? r_rf[w_in_s[RIW-1:0]] : '0);
    end

    // Divider
    logic          w_div_done;
    logic [DW-1:0] w_quot;
    rme_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_a(r_a), .i_b(r_b), .o_done(w_div_done), .o_q(w_quot)
    );
    assign o_sts.need_div = (w_op == OP_DIV) && (r_b != '0);
    assign o_sts.div_done = w_div_done;

    // Product registered at decode
    logic [DW-1:0] r_prod;

    // Return stack, read address prepared as depth minus one
    logic [PCW-1:0] w_ret_pc;
    logic           w_push;
    logic [SAW-1:0] w_top;
    logic [PCW-1:0] w_next_seq;
    assign w_top = (r_sd == '0) ? '0 : SAW'(r_sd - 1'b1);
    rme_ram #(.WIDTH(PCW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_push), .i_waddr(SAW'(r_sd)), .i_wdata(w_next_seq),
        .i_raddr(w_top), .o_rdata(w_ret_pc)
    );

    // Execute
    logic [PCW-1:0] w_len, w_next;
    logic [2:0]     w_st;
    logic [DW-1:0]  w_v, w_diff, w_x;
    logic           w_wr, w_jump, w_zf, w_nf, w_wen;
    logic [SDW-1:0] w_sd;
    always_comb begin
        w_len = (32'(i_prog_len) > 32'(PROG_DEPTH)) ? PCW'(PROG_DEPTH) : i_prog_len;
        w_st = r_st; w_next = r_pc; w_v = '0; w_wr = 1'b0; w_jump = 1'b0;
        w_zf = r_zf; w_nf = r_nf; w_sd = r_sd; w_push = 1'b0; w_wen = 1'b0;
        w_next_seq = r_pc + 1'b1;
        w_x = w_fimm ? w_fv : r_a;
        w_diff = w_x - r_b;
        if (w_st == ST_RUN && r_pc >= w_len) w_st = ST_FELL;
        if (w_st == ST_RUN) begin
            w_next = w_next_seq;
            case (w_op)
                OP_MOV: begin w_v = r_b; w_wr = 1'b1; end
                OP_INC: begin w_v = r_a + 1'b1; w_wr = 1'b1; end
                OP_DEC: begin w_v = r_a - 1'b1; w_wr = 1'b1; end
                OP_ADD: begin w_v = r_a + r_b; w_wr = 1'b1; end
                OP_SUB: begin w_v = r_a - r_b; w_wr = 1'b1; end
                OP_MUL: begin w_v = r_prod; w_wr = 1'b1; end
                OP_DIV: begin
                    if (r_b == '0) w_st = ST_DIV0;
                    else begin w_v = w_quot; w_wr = 1'b1; end
                end
                OP_CMP: begin w_zf = (w_diff == '0); w_nf = w_diff[DW-1]; end
                OP_JMP: w_jump = 1'b1;
                OP_JNE: w_jump = !r_zf;
                OP_JE:  w_jump = r_zf;
                OP_JG:  w_jump = !r_nf && !r_zf;
                OP_JGE: w_jump = !r_nf || r_zf;
                OP_JL:  w_jump = r_nf;
                OP_JLE: w_jump = r_nf || r_zf;
                OP_CALL: begin
                    if (32'(r_sd) >= 32'(STACK_DEPTH)) w_st = ST_STACK;
                    else if (!w_found) w_st = ST_NOLBL;
                    else begin
                        w_push = i_cmd.commit;
                        w_sd = r_sd + 1'b1;
                        w_next = PCW'(w_tgt);
                    end
                end
                OP_RET: begin
                    if (r_sd == '0) w_st = ST_BADRET;
                    else begin
                        w_sd = r_sd - 1'b1;
                        w_next = w_ret_pc;
                    end
                end
                default: w_st = ST_END;
            endcase
            if (w_jump) begin
                if (!w_found) w_st = ST_NOLBL;
                else w_next = PCW'(w_tgt);
            end
            w_wen = w_wr && (32'(w_d) < 32'(REG_COUNT));
            if (!w_wen) w_v = '0;
            if (w_st != ST_RUN) w_next = r_pc;
            else if (w_next >= w_len) w_st = ST_FELL;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_rf[i] <= '0;
            r_zf <= 1'b0; r_nf <= 1'b0; r_sd <= '0; r_pc <= '0; r_st <= ST_RUN;
        end else if (i_cmd.commit) begin
            if (w_wen) r_rf[w_d[RIW-1:0]] <= w_v;
            r_zf <= w_zf; r_nf <= w_nf; r_sd <= w_sd; r_pc <= w_next; r_st <= w_st;
        end
    end

    // Operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_a <= w_ra;
            r_b <= w_rb;
        end
        r_prod <= r_a * r_b;
        if (i_cmd.commit) r_res <= {w_nf, w_zf, w_v, w_st, w_next};
    end
    // Result: next_pc, run_status, written_value, zero_flag, negative_flag
    assign o_res = r_res;
endmodule

FILE: hw/rtl/register_machine_execute_top.sv
// Top level of the register machine execute block.
// Depends on rme_pkg, rme_ctrl, rme_dp.
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: request fields
// m_axis    out  tvalid/tready          tdata: next_pc, run_status, written_value, flags
// apb       in   psel/penable/pwrite    prog_length at address 0
//
// A plain instruction passes from idle through decode and commit, its result
// registered at commit; a divide also waits in the divide state, where the divider
// makes one quotient bit per cycle. Instructions run one at a time since each reads the
// state the previous one leaves. Synchronous reset clears registers, flags, pc,
// status and stack depth. A stalled output holds the controller in its commit state.
`timescale 1ns / 1ps
module register_machine_execute_top #(
    parameter int REG_COUNT   = rme_pkg::REG_COUNT_DEF,
    parameter int STACK_DEPTH = rme_pkg::STACK_DEPTH_DEF,
    parameter int PROG_DEPTH  = rme_pkg::PROG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type, dest_reg, first_is_imm, first_imm, second_is_imm, src_reg,
    // immediate, target_index, target_found; zero fill to 96 bits
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc, run_status, written_value, zero_flag, negative_flag; exactly 48 bits, no fill
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rme_pkg::*;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [10:0] r_prog_len;
    logic [47:0] w_res;
    logic [91:0] w_req;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prog_len <= '0;
        else if (psel && penable && pwrite && paddr[2:2] == RA_PROG_LEN[0:0])
            r_prog_len <= pwdata[10:0];
    end
    assign prdata = (paddr[2:2] == RA_PROG_LEN[0:0]) ? {21'd0, r_prog_len} : '0;

    // Request fields without the zero fill
    assign w_req = s_axis_tdata[91:0];

    rme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    rme_dp #(.REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH), .PROG_DEPTH(PROG_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_prog_len(r_prog_len), .i_req(w_req), .o_res(w_res)
    );

    // Result register already holds the packed fields
    assign m_axis_tdata = w_res;
endmodule

FILE: hw/rtl/rme_chk.sv
// Port checker for the register machine execute block, bound to the top level.
// Depends on register_machine_execute_top.
`timescale 1ns / 1ps
module rme_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // Output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // No new request taken in the cycle after one was accepted
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");
    // A result never appears right after accept
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind register_machine_execute_top rme_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
